// ===== rtl/swr_pkg.sv =====
// Shared types, codes and default sizes for the segment window reassembly block.
package swr_pkg;

    localparam int WINDOW_SEGMENTS_DEF = 16;
    localparam int MAX_PACKETS_DEF     = 64;

    localparam int ID_W    = 32;
    localparam int COUNT_W = 7;
    localparam int SEQ_W   = 8;
    localparam int STAT_W  = 3;
    localparam int SLOT_W  = 4;
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    typedef enum logic [0:0] {
        OP_PUSH = 1'b0,
        OP_TICK = 1'b1
    } t_opcode;

    typedef enum logic [STAT_W-1:0] {
        STAT_NOT_USED      = 3'd0,
        STAT_COMPLETE      = 3'd1,
        STAT_PARTIAL       = 3'd2,
        STAT_OUT_OF_WINDOW = 3'd3,
        STAT_TICK_DONE     = 3'd4
    } t_status;

    typedef enum logic [0:0] {
        REG_START_ID = 1'b0,
        REG_PPSEG    = 1'b1
    } t_reg_idx;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_EXEC
    } t_state;

    // Configuration as seen by the datapath
    typedef struct packed {
        logic               restart;    // start ID written this cycle
        logic [ID_W-1:0]    start_val;  // value being written on restart
        logic [COUNT_W-1:0] ppseg;      // packets_per_segment register
    } t_cfg;

endpackage

// ===== rtl/swr_cfg.sv =====
// APB configuration registers for the segment window reassembly block.
module swr_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swr_pkg::PADDR_W-1:0]   paddr,
    input  logic [swr_pkg::PDATA_W-1:0]   pwdata,
    output logic [swr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready,
    output swr_pkg::t_cfg                 o_cfg
);
    import swr_pkg::*;

    logic [ID_W-1:0]    r_start_id;
    logic [COUNT_W-1:0] r_ppseg;
    logic               wr_stb;

    assign pready = 1'b1;
    assign wr_stb = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_id <= '0;
            r_ppseg    <= COUNT_W'(64);
        end else if (wr_stb) begin
            case (t_reg_idx'(paddr[2]))
                REG_START_ID: r_start_id <= pwdata[ID_W-1:0];
                REG_PPSEG:    r_ppseg    <= pwdata[COUNT_W-1:0];
                default:      r_ppseg    <= r_ppseg;
            endcase
        end
    end

    always_comb begin
        case (t_reg_idx'(paddr[2]))
            REG_START_ID: prdata = r_start_id;
            REG_PPSEG:    prdata = PDATA_W'(r_ppseg);
            default:      prdata = '0;
        endcase
    end

    assign o_cfg.restart   = wr_stb && (t_reg_idx'(paddr[2]) == REG_START_ID);
    assign o_cfg.start_val = pwdata[ID_W-1:0];
    assign o_cfg.ppseg     = r_ppseg;

endmodule

// ===== rtl/swr_mem.sv =====
// Slot memory: per-slot bitmap and complete flag, registered read, valid bits per entry.
module swr_mem #(
    parameter int DEPTH = swr_pkg::WINDOW_SEGMENTS_DEF,
    parameter int WIDTH = swr_pkg::MAX_PACKETS_DEF + 1,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_inv_en,
    input  logic             i_clr_all
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [WIDTH-1:0] r_rd_mem;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_mem <= r_mem[i_rd_addr];
        end
    end

    // Invalidation always targets the slot last read (the retired slot)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_rd_en) begin
                r_rd_vld <= r_valid[i_rd_addr];
            end
            if (i_clr_all) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end else if (i_inv_en) begin
                r_valid[i_wr_addr] <= 1'b0;
            end
        end
    end

    // A slot never written since it was cleared reads as empty
    assign o_rd_data = r_rd_vld ? r_rd_mem : '0;

endmodule

// ===== rtl/segment_window_reassembly.sv =====
// Segment window reassembly tracker: top level with window control and result register.
//
// Tracks a window of WINDOW_SEGMENTS consecutive segment IDs, each with a packet
// bitmap and complete flag held in one slot memory. Every item (push or tick) is
// accepted in the idle state, where its slot is read into the memory's read register;
// the modify, write-back and result follow in the execute state. The input takes no
// new item until the last one has left the execute state, and a held result stalls
// that state until it is taken. Writing start_segment_id restarts the window at
// once and clears every slot through per-slot valid bits, so no clearing pass is needed.
module segment_window_reassembly #(
    parameter int WINDOW_SEGMENTS = swr_pkg::WINDOW_SEGMENTS_DEF,
    parameter int MAX_PACKETS     = swr_pkg::MAX_PACKETS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic                          i_opcode,
    input  logic [swr_pkg::ID_W-1:0]      i_segment_id,
    input  logic [swr_pkg::SEQ_W-1:0]     i_packet_seq,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [swr_pkg::STAT_W-1:0]    o_status,
    output logic                          o_write_enable,
    output logic [swr_pkg::SLOT_W-1:0]    o_slot_index,
    output logic                          o_retired_complete,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [swr_pkg::PADDR_W-1:0]   paddr,
    input  logic [swr_pkg::PDATA_W-1:0]   pwdata,
    output logic [swr_pkg::PDATA_W-1:0]   prdata,
    output logic                          pready
);
    import swr_pkg::*;

    localparam int SW = $clog2(WINDOW_SEGMENTS);
    localparam int MP = MAX_PACKETS;
    localparam int EW = MP + 1;

    t_cfg              cfg;
    t_state            r_state, n_state;

    logic [ID_W-1:0]   r_base;
    logic [SW-1:0]     r_head;

    // Item captured at accept
    t_opcode           r_op;
    logic [SEQ_W-1:0]  r_seq;
    logic [SW-1:0]     r_slot;
    logic              r_in_win;

    // Result register
    logic              r_out_valid;
    t_status           r_status;
    logic              r_we;
    logic [SW-1:0]     r_out_slot;
    logic              r_retired;

    logic              accept;
    logic              exec_done;

    logic [ID_W-1:0]   offset;
    logic              in_win;
    logic [SW:0]       slot_sum;
    logic [SW-1:0]     push_slot;
    logic [SW-1:0]     rd_slot;

    logic [EW-1:0]     rd_data;
    logic [MP-1:0]     cur_bm;
    logic              cur_cmp;
    logic [COUNT_W-1:0] eff_cnt;
    logic [MP-1:0]     full_mask;
    logic [MP-1:0]     seq_bit;
    logic [MP-1:0]     new_bm;
    logic              seq_bad;
    logic              dup;
    logic              is_new;
    logic              now_cmp;
    logic              is_tick;

    t_status           res_status;
    logic              res_we;
    logic [SW-1:0]     res_slot;
    logic              res_retired;

    swr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // ---------------- accept stage: locate the slot and read it
    assign offset    = i_segment_id - r_base;
    assign in_win    = offset < ID_W'(WINDOW_SEGMENTS);
    assign slot_sum  = (SW+1)'(r_head) + (SW+1)'(offset[SW-1:0]);
    assign push_slot = (slot_sum >= (SW+1)'(WINDOW_SEGMENTS))
                       ? SW'(slot_sum - (SW+1)'(WINDOW_SEGMENTS)) : SW'(slot_sum);
    assign rd_slot   = (i_opcode == OP_TICK) ? r_head : push_slot;

    // ---------------- FSM
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (i_in_valid) begin
                n_state = ST_EXEC;
            end
            ST_EXEC: if (!r_out_valid || i_out_ready) begin
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                exec_done  = 1'b0;
            end
            ST_EXEC: begin
                o_in_ready = 1'b0;
                exec_done  = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
                exec_done  = 1'b0;
            end
        endcase
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op     <= t_opcode'(i_opcode);
            r_seq    <= i_packet_seq;
            r_slot   <= rd_slot;
            r_in_win <= in_win;
        end
    end

    // ---------------- execute stage: classify, modify and write back
    assign cur_bm  = rd_data[MP-1:0];
    assign cur_cmp = rd_data[MP];

    always_comb begin
        if (cfg.ppseg == '0) begin
            eff_cnt = COUNT_W'(1);
        end else if (cfg.ppseg > COUNT_W'(MP)) begin
            eff_cnt = COUNT_W'(MP);
        end else begin
            eff_cnt = cfg.ppseg;
        end
    end

    always_comb begin
        for (int i = 0; i < MP; i++) begin
            full_mask[i] = COUNT_W'(i) < eff_cnt;
        end
    end

    assign seq_bit = MP'(1) << r_seq;
    assign new_bm  = cur_bm | seq_bit;
    assign seq_bad = r_seq >= SEQ_W'(eff_cnt);
    assign dup     = |(cur_bm & seq_bit);
    assign is_tick = r_op == OP_TICK;
    assign is_new  = !is_tick && r_in_win && !seq_bad && !cur_cmp && !dup;
    assign now_cmp = (new_bm & full_mask) == full_mask;

    always_comb begin
        res_we      = 1'b0;
        res_retired = 1'b0;
        res_slot    = r_slot;
        if (is_tick) begin
            res_status  = STAT_TICK_DONE;
            res_retired = cur_cmp;
        end else if (!r_in_win) begin
            res_status = STAT_OUT_OF_WINDOW;
            res_slot   = '0;
        end else if (is_new) begin
            res_we     = 1'b1;
            res_status = now_cmp ? STAT_COMPLETE : STAT_PARTIAL;
        end else begin
            res_status = STAT_NOT_USED;
        end
    end

    swr_mem #(
        .DEPTH (WINDOW_SEGMENTS),
        .WIDTH (EW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_slot),
        .o_rd_data (rd_data),
        .i_wr_en   (exec_done && is_new),
        .i_wr_addr (r_slot),
        .i_wr_data ({now_cmp, new_bm}),
        .i_inv_en  (exec_done && is_tick),
        .i_clr_all (cfg.restart)
    );

    // Window position: restart on config, advance on tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= '0;
            r_head <= '0;
        end else if (cfg.restart) begin
            r_base <= cfg.start_val;
            r_head <= '0;
        end else if (exec_done && is_tick) begin
            r_base <= r_base + 1'b1;
            r_head <= (r_head == SW'(WINDOW_SEGMENTS - 1)) ? '0 : r_head + 1'b1;
        end
    end

    // ---------------- result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (exec_done) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec_done) begin
            r_status   <= res_status;
            r_we       <= res_we;
            r_out_slot <= res_slot;
            r_retired  <= res_retired;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_status           = r_status;
    assign o_write_enable     = r_we;
    assign o_slot_index       = SLOT_W'(r_out_slot);
    assign o_retired_complete = r_retired;

`ifndef ASSERT_OFF
    a_we_only_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_write_enable) |->
        (o_status == STAT_COMPLETE || o_status == STAT_PARTIAL))
        else $error("write enable on a result that is not a new packet");

    a_oow_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == STAT_OUT_OF_WINDOW) |->
        (!o_write_enable && o_slot_index == '0 && !o_retired_complete))
        else $error("out-of-window result carries slot or write enable");

    a_accept_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == ST_EXEC && !o_in_ready))
        else $error("accepted item did not move to execute");

    a_tick_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec_done && is_tick && !cfg.restart) |=> (r_base == $past(r_base) + 1'b1))
        else $error("tick did not advance the window base");
`endif

endmodule

// ===== bench/tb_segment_window_reassembly.sv =====
// Self-checking testbench for the segment window reassembly tracker.
`timescale 1ns / 100ps

module tb_segment_window_reassembly;
    import swr_pkg::*;

    localparam int WIN        = WINDOW_SEGMENTS_DEF;
    localparam int MAXP       = MAX_PACKETS_DEF;
    localparam int STALL_LIMIT = 4000;

    typedef struct packed {
        t_opcode           op;
        logic [ID_W-1:0]   seg;
        logic [SEQ_W-1:0]  seq;
    } t_item;

    typedef struct packed {
        t_status           status;
        logic              wr_en;
        logic [SLOT_W-1:0] slot;
        logic              retired;
    } t_verdict;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_in_valid = 1'b0;
    logic               o_in_ready;
    logic               i_opcode = 1'b0;
    logic [ID_W-1:0]    i_segment_id = '0;
    logic [SEQ_W-1:0]   i_packet_seq = '0;
    logic               o_out_valid;
    logic               i_out_ready = 1'b0;
    logic [STAT_W-1:0]  o_status;
    logic               o_write_enable;
    logic [SLOT_W-1:0]  o_slot_index;
    logic               o_retired_complete;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    segment_window_reassembly dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_opcode           (i_opcode),
        .i_segment_id       (i_segment_id),
        .i_packet_seq       (i_packet_seq),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_status           (o_status),
        .o_write_enable     (o_write_enable),
        .o_slot_index       (o_slot_index),
        .o_retired_complete (o_retired_complete),
        .psel               (psel),
        .penable            (penable),
        .pwrite             (pwrite),
        .paddr              (paddr),
        .pwdata             (pwdata),
        .prdata             (prdata),
        .pready             (pready)
    );

    always #4 i_clk = ~i_clk;

    // Window tracker mirror
    logic [ID_W-1:0]    base_id = '0;
    logic [SLOT_W-1:0]  head_ptr = '0;
    logic [MAXP-1:0]    pkt_map [WIN];
    logic               seg_done [WIN];
    logic [COUNT_W-1:0] ppseg_reg = COUNT_W'(MAXP);

    // Generator view of the window base, advanced as ticks are queued
    logic [ID_W-1:0]    gen_base = '0;

    t_item    item_q [$];
    t_verdict verdict_q [$];
    t_item    cur_item;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int n_push = 0, n_tick = 0, n_complete = 0, n_oow = 0, n_retired_done = 0;

    function automatic int eff_count(logic [COUNT_W-1:0] p);
        if (p == 0)
            return 1;
        if (p > MAXP)
            return MAXP;
        return p;
    endfunction

    function automatic t_verdict classify_item(t_item it);
        t_verdict v;
        logic [ID_W-1:0]   offset;
        logic [SLOT_W-1:0] s;
        logic [MAXP-1:0]   full;
        int n;
        v = '0;
        v.status = STAT_NOT_USED;
        if (it.op == OP_TICK) begin
            n_tick++;
            v.status  = STAT_TICK_DONE;
            v.slot    = head_ptr;
            v.retired = seg_done[head_ptr];
            if (seg_done[head_ptr])
                n_retired_done++;
            pkt_map[head_ptr]  = '0;
            seg_done[head_ptr] = 1'b0;
            head_ptr = SLOT_W'((head_ptr + 1) % WIN);
            base_id  = base_id + 1;
        end else begin
            n_push++;
            offset = it.seg - base_id;
            if (offset >= WIN) begin
                n_oow++;
                v.status = STAT_OUT_OF_WINDOW;
            end else begin
                n = eff_count(ppseg_reg);
                s = SLOT_W'((head_ptr + offset) % WIN);
                v.slot = s;
                full = (n >= MAXP) ? '1 : ((MAXP'(1) << n) - 1);
                if (!(it.seq >= n || seg_done[s] || pkt_map[s][it.seq[5:0]])) begin
                    pkt_map[s][it.seq[5:0]] = 1'b1;
                    v.wr_en = 1'b1;
                    if ((pkt_map[s] & full) == full) begin
                        seg_done[s] = 1'b1;
                        v.status = STAT_COMPLETE;
                        n_complete++;
                    end else begin
                        v.status = STAT_PARTIAL;
                    end
                end
            end
        end
        return v;
    endfunction

    // Item driver
    always @(posedge i_clk) begin : drive
        logic fire;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            fire = i_in_valid && o_in_ready;
            if (fire)
                verdict_q.push_back(classify_item(cur_item));
            if (!i_in_valid || fire) begin
                if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_item = item_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_opcode     <= cur_item.op;
                    i_segment_id <= cur_item.seg;
                    i_packet_seq <= cur_item.seq;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string fname, int want, int got);
        if (want != got) begin
            err_count++;
            $display("%0t ns: %s mismatch: expected %0d, actual %0d", $time, fname, want, got);
        end
    endtask

    // Result monitor
    always @(posedge i_clk) begin : monitor
        t_verdict want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (verdict_q.size() == 0) begin
                    err_count++;
                    $display("%0t ns: unexpected result: expected none, actual status %0d",
                             $time, o_status);
                end else begin
                    want = verdict_q.pop_front();
                    check_field("status", want.status, o_status);
                    check_field("write_enable", want.wr_en, o_write_enable);
                    check_field("slot_index", want.slot, o_slot_index);
                    check_field("retired_complete", want.retired, o_retired_complete);
                end
            end
            i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: count cycles without any handshake
    always @(posedge i_clk) begin : watchdog
        int quiet;
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t ns: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    task automatic cfg_write(t_reg_idx idx, logic [PDATA_W-1:0] val);
        int k;
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_START_ID) begin
            for (k = 0; k < WIN; k++) begin
                pkt_map[k]  = '0;
                seg_done[k] = 1'b0;
            end
            head_ptr = '0;
            base_id  = val;
            gen_base = val;
        end else begin
            ppseg_reg = val[COUNT_W-1:0];
        end
    endtask

    task automatic add_push(logic [ID_W-1:0] seg, logic [SEQ_W-1:0] seq);
        item_q.push_back('{OP_PUSH, seg, seq});
    endtask

    task automatic add_tick();
        item_q.push_back('{OP_TICK, ID_W'($urandom), SEQ_W'($urandom)});
        gen_base = gen_base + 1;
    endtask

    // Mostly in-window pushes with random content, some full-segment sweeps,
    // ticks, and a share of stray or edge-of-window pushes.
    task automatic gen_items(int count);
        int made, r, n, off, k, j, tmp;
        int order [$];
        made = 0;
        n = eff_count(ppseg_reg);
        while (made < count) begin
            r = $urandom_range(99);
            if (r < 7) begin
                add_tick();
                made++;
            end else if (r < 17) begin
                add_push(ID_W'($urandom), SEQ_W'($urandom_range(255)));
                made++;
            end else if (r < 21) begin
                case ($urandom_range(2))
                    0: add_push(gen_base - 1, SEQ_W'($urandom_range(n - 1)));
                    1: add_push(gen_base + WIN, SEQ_W'($urandom_range(n - 1)));
                    default: add_push(gen_base + WIN - 1, SEQ_W'($urandom_range(n - 1)));
                endcase
                made++;
            end else if (r < 23) begin
                off = $urandom_range(WIN - 1);
                order.delete();
                for (k = 0; k < n; k++)
                    order.push_back(k);
                for (k = n - 1; k > 0; k--) begin
                    j = $urandom_range(k);
                    tmp = order[k];
                    order[k] = order[j];
                    order[j] = tmp;
                end
                foreach (order[k])
                    add_push(gen_base + off, SEQ_W'(order[k]));
                made += n;
            end else begin
                off = $urandom_range(1) ? $urandom_range(3) : $urandom_range(WIN - 1);
                add_push(gen_base + off, SEQ_W'($urandom_range(n)));
                made++;
            end
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge i_clk);
        while (item_q.size() != 0 || i_in_valid || verdict_q.size() != 0);
    endtask

    // Hold the sender halfway through so the block fully drains mid-phase, and again at the end.
    task automatic run_phase(int send_pct, int recv_pct, int count);
        @(negedge i_clk);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        gen_items(count / 2);
        wait_drained();
        gen_items(count - count / 2);
        wait_drained();
    endtask

    initial begin : stimulus
        logic [ID_W-1:0] b;
        int k;
        for (k = 0; k < WIN; k++) begin
            pkt_map[k]  = '0;
            seg_done[k] = 1'b0;
        end
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: window straddling the ID wrap, four packets per segment
        cfg_write(REG_START_ID, 32'hFFFF_FFF8);
        cfg_write(REG_PPSEG, 32'd4);
        @(negedge i_clk);
        b = gen_base;
        add_push(b, 0);
        add_push(b, 0);                // duplicate
        add_push(b, 3);
        add_push(b, 1);
        add_push(b, 2);                // completes
        add_push(b, 0);                // segment already complete
        add_push(b + 1, 4);            // packet number too large
        add_push(b + 1, 255);
        add_push(b + 7, 0);            // ID all ones
        add_push(b + 8, 3);            // ID zero after wrap
        add_push(b + WIN - 1, 0);      // newest slot
        add_push(b + WIN, 0);          // one past the window
        add_push(b - 1, 0);            // one before the window
        add_push(32'h7FFF_FFFF, 0);
        add_tick();                    // retires a complete segment
        add_tick();
        add_push(b + WIN, 0);          // now inside, reuses slot zero
        wait_drained();

        cfg_write(REG_PPSEG, 32'd1);
        @(negedge i_clk);
        add_push(b + 3, 0);
        add_push(b + 3, 1);
        wait_drained();

        cfg_write(REG_PPSEG, 32'd0);   // acts as one
        @(negedge i_clk);
        add_push(b + 4, 0);
        add_push(b + 4, 1);
        wait_drained();

        cfg_write(REG_PPSEG, 32'd127); // clamps to the maximum
        @(negedge i_clk);
        add_push(b + 5, 63);
        add_push(b + 5, 64);
        add_tick();
        wait_drained();

        cfg_write(REG_START_ID, $urandom);
        cfg_write(REG_PPSEG, 32'd8);
        run_phase(0, 0, 450);

        cfg_write(REG_START_ID, 32'hFFFF_FFFF);
        cfg_write(REG_PPSEG, 32'd64);
        run_phase(77, 0, 450);

        // Count change only: bitmaps and complete flags carry over
        cfg_write(REG_PPSEG, 32'd1);
        run_phase(0, 77, 450);

        cfg_write(REG_START_ID, 32'd0);
        cfg_write(REG_PPSEG, 32'd3);
        run_phase(11, 11, 450);

        repeat (10) @(posedge i_clk);
        $display("Covered %0d pushes and %0d ticks over window restarts and count changes:",
                 n_push, n_tick);
        $display("  %0d completions, %0d out-of-window, %0d complete retirements",
                 n_complete, n_oow, n_retired_done);
        if (err_count == 0 && verdict_q.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d results never arrived", err_count, verdict_q.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
